@@ rtl/core/bctc_pkg.sv @@
// ---------------------------------------------------------------------------
// bctc_pkg
// Shared widths, entry record and controller states for the block cache
// tag controller.
// ---------------------------------------------------------------------------
`default_nettype none

package bctc_pkg;

  // Field widths
  localparam int TAG_W  = 32;   // block number / tag
  localparam int CFG_W  = 13;   // lbas_per_block
  localparam int SLOT_W = 9;    // slot field of a result
  localparam int LBA_W  = 48;   // start LBA fields
  localparam int PROD_W = TAG_W + CFG_W;

  // Defaults
  localparam int            DEF_ENTRIES = 512;
  localparam logic [CFG_W-1:0] LPB_RESET = CFG_W'(8);

  // One tag store entry: dirty flag plus the block it holds
  typedef struct packed {
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL_FILL,
    ST_MUL_WB,
    ST_FINISH
  } ctrl_state_t;

endpackage

`default_nettype wire

@@ rtl/core/bctc_tag_mem.sv @@
// ---------------------------------------------------------------------------
// bctc_tag_mem
// Tag store: one write port and one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bctc_tag_mem #(
  parameter int ENTRIES = bctc_pkg::DEF_ENTRIES,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output bctc_pkg::entry_t      rd_data,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire bctc_pkg::entry_t wr_data
);

  import bctc_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/bctc_lba_mul.sv @@
// ---------------------------------------------------------------------------
// bctc_lba_mul
// Start LBA multiplier: block number times lbas_per_block, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module bctc_lba_mul (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [bctc_pkg::TAG_W-1:0]  blk,
  input  wire logic [bctc_pkg::CFG_W-1:0]  lpb,
  output logic      [bctc_pkg::PROD_W-1:0] prod
);

  import bctc_pkg::*;

  logic [PROD_W-1:0] prod_r;

  // 32 x 13 product, held while not enabled
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(blk) * PROD_W'(lpb);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

@@ rtl/core/block_cache_tag_controller.sv @@
// ---------------------------------------------------------------------------
// block_cache_tag_controller
// Tag and round-robin replacement control for a fully associative,
// write-back block cache.
// ---------------------------------------------------------------------------
// Each request is resolved against a tag store held in one synchronous
// memory that is read one entry per cycle. A request issues the read of
// entry zero, scans the filled entries in index order until a hit or the
// last filled entry, runs the shared LBA multiplier for the fill LBA and
// then the victim LBA (ST_MUL_FILL, ST_MUL_WB), and loads the result
// register in ST_FINISH. Entries are taken in index order until the
// store is full, so a fill count marks which entries are in use and no
// clearing pass is needed after reset. A new request is taken while the
// previous result still waits on the output.
// ---------------------------------------------------------------------------
`default_nettype none

module block_cache_tag_controller #(
  parameter int ENTRIES = bctc_pkg::DEF_ENTRIES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Configuration
  input  wire logic                       cfg_wr_en,
  input  wire logic [bctc_pkg::CFG_W-1:0] cfg_wr_data,
  // Request channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [bctc_pkg::TAG_W-1:0] in_block_number,
  input  wire logic                       in_is_write,
  // Result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_hit,
  output logic [bctc_pkg::SLOT_W-1:0]     out_slot,
  output logic                            out_fill_needed,
  output logic [bctc_pkg::LBA_W-1:0]      out_fill_lba,
  output logic                            out_writeback_needed,
  output logic [bctc_pkg::LBA_W-1:0]      out_writeback_lba
);

  import bctc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  // Control and request registers
  ctrl_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic [IDX_W-1:0]  vp_r, vp_nxt;
  logic [CFG_W-1:0]  lpb_r;
  logic [TAG_W-1:0]  blk_r, blk_nxt;
  logic              wr_r, wr_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  entry_t            vic_r, vic_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic              wb_r, wb_nxt;
  logic [LBA_W-1:0]  fill_lba_r, fill_lba_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_fill_r;
  logic [LBA_W-1:0]  out_fill_lba_r;
  logic              out_wb_r;
  logic [LBA_W-1:0]  out_wb_lba_r;
  logic              out_load;

  // Memory and multiplier hookup
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              mul_en;
  logic [TAG_W-1:0]  mul_a;
  logic [PROD_W-1:0] mul_p;
  logic [LBA_W-1:0]  mul_lba;

  // Scan helpers
  logic              in_xfer;
  logic              scan_hit;
  logic              scan_last;
  logic              full;
  logic [SLOT_W+IDX_W-1:0] slot_ext;

  bctc_tag_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_tag_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bctc_lba_mul u_lba_mul (
    .clk  (clk),
    .en   (mul_en),
    .blk  (mul_a),
    .lpb  (lpb_r),
    .prod (mul_p)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign full     = (fill_cnt_r == FULL_CNT);
  assign mul_lba  = {{(LBA_W - PROD_W){1'b0}}, mul_p};

  // Entry under compare is in use for every scanned index below fill count
  assign scan_hit  = (fill_cnt_r != '0) && (rd_data.tag == blk_r);
  assign scan_last = (fill_cnt_r == '0) ||
                     ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == fill_cnt_r);

  // Multiplier runs for the fill LBA, then the victim LBA
  assign mul_en = (state_r == ST_MUL_FILL) || (state_r == ST_MUL_WB);
  assign mul_a  = (state_r == ST_MUL_WB) ? vic_r.tag : blk_r;

  // Next state, memory controls and request bookkeeping
  always_comb begin
    state_nxt    = state_r;
    fill_cnt_nxt = fill_cnt_r;
    vp_nxt       = vp_r;
    blk_nxt      = blk_r;
    wr_nxt       = wr_r;
    cmp_idx_nxt  = cmp_idx_r;
    vic_nxt      = vic_r;
    hit_nxt      = hit_r;
    slot_nxt     = slot_r;
    wb_nxt       = wb_r;
    fill_lba_nxt = fill_lba_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    out_load     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          blk_nxt     = in_block_number;
          wr_nxt      = in_is_write;
          cmp_idx_nxt = '0;
          rd_en       = 1'b1;
          rd_addr     = '0;
          state_nxt   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Keep the victim entry as it streams past
        if (cmp_idx_r == vp_r) begin
          vic_nxt = rd_data;
        end
        if (scan_hit) begin
          hit_nxt   = 1'b1;
          slot_nxt  = cmp_idx_r;
          wb_nxt    = 1'b0;
          wr_en     = 1'b1;
          wr_addr   = cmp_idx_r;
          wr_data   = '{dirty: rd_data.dirty | wr_r, tag: blk_r};
          state_nxt = ST_MUL_FILL;
        end else if (scan_last) begin
          hit_nxt = 1'b0;
          wr_en   = 1'b1;
          wr_data = '{dirty: wr_r, tag: blk_r};
          if (full) begin
            // Evict under the round-robin pointer
            slot_nxt = vp_r;
            wr_addr  = vp_r;
            wb_nxt   = vic_nxt.dirty;
            vp_nxt   = (vp_r == LAST_IDX) ? '0 : vp_r + IDX_W'(1);
          end else begin
            // Next free entry sits at the fill count
            slot_nxt     = fill_cnt_r[IDX_W-1:0];
            wr_addr      = fill_cnt_r[IDX_W-1:0];
            wb_nxt       = 1'b0;
            fill_cnt_nxt = fill_cnt_r + CNT_W'(1);
          end
          state_nxt = ST_MUL_FILL;
        end else begin
          cmp_idx_nxt = cmp_idx_r + IDX_W'(1);
          rd_en       = 1'b1;
          rd_addr     = cmp_idx_r + IDX_W'(1);
        end
      end

      ST_MUL_FILL: begin
        state_nxt = ST_MUL_WB;
      end

      ST_MUL_WB: begin
        fill_lba_nxt = mul_lba;
        state_nxt    = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign slot_ext = {{SLOT_W{1'b0}}, slot_r};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_cnt_r  <= '0;
      vp_r        <= '0;
      lpb_r       <= LPB_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      vp_r        <= vp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        lpb_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    wr_r       <= wr_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    vic_r      <= vic_nxt;
    hit_r      <= hit_nxt;
    slot_r     <= slot_nxt;
    wb_r       <= wb_nxt;
    fill_lba_r <= fill_lba_nxt;
    if (out_load) begin
      out_hit_r      <= hit_r;
      out_slot_r     <= slot_ext[SLOT_W-1:0];
      out_fill_r     <= !hit_r;
      out_fill_lba_r <= hit_r ? '0 : fill_lba_r;
      out_wb_r       <= wb_r;
      out_wb_lba_r   <= wb_r ? mul_lba : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_slot             = out_slot_r;
  assign out_fill_needed      = out_fill_r;
  assign out_fill_lba         = out_fill_lba_r;
  assign out_writeback_needed = out_wb_r;
  assign out_writeback_lba    = out_wb_lba_r;

endmodule

`default_nettype wire
